>>> hw/rtl/kwda_pkg.sv
// ----------------------------------------------------------------------------
// kwda_pkg: shared constants and types of the knob wrap delta accumulator
// Field widths, derived arithmetic widths and the divider request/response.
// ----------------------------------------------------------------------------
package kwda_pkg;

    // Number of knob channels; a power of two no larger than the channel field.
    localparam int CHANNELS      = 16;
    localparam int CH_FIELD_BITS = 4;
    localparam int CH_IDX_BITS   = $clog2(CHANNELS);

    localparam int VALUE_BITS    = 16;
    localparam int FRAC_BITS     = 16;

    // A difference of two readings needs one more bit, a sum of two differences two.
    localparam int DELTA_BITS    = VALUE_BITS + 2;
    localparam int RANGE_BITS    = VALUE_BITS + 1;
    localparam int MAG_BITS      = VALUE_BITS + 1;
    localparam int DIVIDEND_BITS = MAG_BITS + FRAC_BITS;
    localparam int TERM_BITS     = DIVIDEND_BITS + 1;
    localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS + 1);

    localparam int TOTAL_BITS    = 40;
    localparam int TURN_BITS     = 48;

    typedef struct packed {
        logic                     start;
        logic [DIVIDEND_BITS-1:0] dividend;
        logic [VALUE_BITS-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic [DIVIDEND_BITS-1:0] quotient;
    } t_div_rsp;

endpackage

>>> hw/rtl/kwda_in_if.sv
// ----------------------------------------------------------------------------
// kwda_in_if: input item channel
// Valid/ready handshake carrying one knob sample.
// ----------------------------------------------------------------------------
interface kwda_in_if import kwda_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [CH_FIELD_BITS-1:0]     channel;
    logic signed [VALUE_BITS-1:0] reading;
    logic signed [VALUE_BITS-1:0] reading_min;
    logic signed [VALUE_BITS-1:0] reading_max;

    modport source (output valid, output channel, output reading, output reading_min,
                    output reading_max, input ready);
    modport sink   (input valid, input channel, input reading, input reading_min,
                    input reading_max, output ready);
endinterface

>>> hw/rtl/kwda_out_if.sv
// ----------------------------------------------------------------------------
// kwda_out_if: result item channel
// Valid/ready handshake carrying the delta and the running totals.
// ----------------------------------------------------------------------------
interface kwda_out_if import kwda_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         first_sample;
    logic signed [DELTA_BITS-1:0] step_delta;
    logic signed [TOTAL_BITS-1:0] total_delta;
    logic signed [TURN_BITS-1:0]  total_turns;

    modport source (output valid, output first_sample, output step_delta,
                    output total_delta, output total_turns, input ready);
    modport sink   (input valid, input first_sample, input step_delta,
                    input total_delta, input total_turns, output ready);
endinterface

>>> hw/rtl/kwda_div.sv
// ----------------------------------------------------------------------------
// kwda_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle, dividend shifted in MSB first.
// ----------------------------------------------------------------------------
module kwda_div import kwda_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                     r_busy;
    logic                     r_done;
    logic [DIV_CNT_BITS-1:0]  r_cnt;
    logic [DIVIDEND_BITS-1:0] r_quo;
    logic [VALUE_BITS-1:0]    r_rem;
    logic [VALUE_BITS-1:0]    r_divisor;

    logic [VALUE_BITS:0]      shifted;
    logic [VALUE_BITS:0]      diff;

    always_comb begin
        shifted = {r_rem, r_quo[DIVIDEND_BITS-1]};
        diff    = shifted - {1'b0, r_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy    <= 1'b1;
                r_cnt     <= DIV_CNT_BITS'(DIVIDEND_BITS);
                r_quo     <= i_req.dividend;
                r_rem     <= '0;
                r_divisor <= i_req.divisor;
            end else if (r_busy) begin
                // The partial remainder stays below the divisor, so it fits the
                // divisor width whether or not the subtraction is taken.
                if (!diff[VALUE_BITS]) begin
                    r_rem <= diff[VALUE_BITS-1:0];
                    r_quo <= {r_quo[DIVIDEND_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= shifted[VALUE_BITS-1:0];
                    r_quo <= {r_quo[DIVIDEND_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> hw/rtl/knob_wrap_delta_accumulator_top.sv
// ----------------------------------------------------------------------------
// knob_wrap_delta_accumulator_top: per-channel knob delta and turn accumulator
// Wrap-corrected reading deltas, saturating delta totals and Q16 turn totals.
// ----------------------------------------------------------------------------
// The block works on one item at a time. An item with a nonzero range passes
// through the PREP and ACC states, the bit-serial divider producing one
// quotient bit per cycle for the turn term, then TERM and TURN; a first
// sample on a channel goes from PREP to DONE and a zero range from ACC to DONE.
// Input ready is high whenever no item is in work, even while the previous
// result still waits in the output register. Channel state lives in registers,
// 16 entries, and reset clears only the per-channel seen bits.
module knob_wrap_delta_accumulator_top import kwda_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kwda_in_if.sink    i_in,
    kwda_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_ACC,
        S_DIV,
        S_TERM,
        S_TURN,
        S_DONE
    } t_state;

    t_state r_state;

    logic [CHANNELS-1:0]          r_seen;
    logic signed [VALUE_BITS-1:0] r_last [CHANNELS];
    logic signed [TOTAL_BITS-1:0] r_dsum [CHANNELS];
    logic signed [TURN_BITS-1:0]  r_tsum [CHANNELS];

    logic [CH_IDX_BITS-1:0]       r_ch;
    logic signed [VALUE_BITS-1:0] r_value;
    logic signed [VALUE_BITS-1:0] r_vmin;
    logic signed [VALUE_BITS-1:0] r_vmax;
    logic                         r_first;
    logic signed [DELTA_BITS-1:0] r_delta;
    logic signed [RANGE_BITS-1:0] r_range;
    logic                         r_neg;
    logic signed [TERM_BITS-1:0]  r_term;
    logic signed [TOTAL_BITS-1:0] r_tot;
    logic signed [TURN_BITS-1:0]  r_turn;

    logic                         r_out_valid;
    logic                         r_o_first;
    logic signed [DELTA_BITS-1:0] r_o_delta;
    logic signed [TOTAL_BITS-1:0] r_o_total;
    logic signed [TURN_BITS-1:0]  r_o_turns;

    logic signed [DELTA_BITS-1:0] val_x;
    logic signed [DELTA_BITS-1:0] min_x;
    logic signed [DELTA_BITS-1:0] max_x;
    logic signed [DELTA_BITS-1:0] prev_x;
    logic signed [DELTA_BITS-1:0] d0;
    logic signed [DELTA_BITS-1:0] mag;
    logic signed [DELTA_BITS-1:0] range_c;
    logic signed [DELTA_BITS-1:0] half;
    logic signed [DELTA_BITS-1:0] delta_c;

    logic signed [TOTAL_BITS:0]   dsum_raw;
    logic signed [TOTAL_BITS-1:0] dsum_c;
    logic signed [TURN_BITS:0]    tsum_raw;
    logic signed [TURN_BITS-1:0]  tsum_c;
    logic [DELTA_BITS-1:0]        delta_abs;
    logic [RANGE_BITS-1:0]        range_abs;
    logic [TERM_BITS-1:0]         term_pos;
    logic signed [TERM_BITS-1:0]  term_c;

    t_div_req div_req;
    t_div_rsp div_rsp;

    // Delta and wrap correction against the stored reading.
    always_comb begin
        val_x   = DELTA_BITS'(r_value);
        min_x   = DELTA_BITS'(r_vmin);
        max_x   = DELTA_BITS'(r_vmax);
        prev_x  = DELTA_BITS'(r_last[r_ch]);
        d0      = val_x - prev_x;
        mag     = d0[DELTA_BITS-1] ? -d0 : d0;
        range_c = max_x - min_x;
        // Adding the sign bit before the shift makes the halving truncate toward zero.
        half    = (range_c + DELTA_BITS'($signed({1'b0, range_c[DELTA_BITS-1]}))) >>> 1;
        if (mag > half) begin
            if (val_x > prev_x) begin
                delta_c = (min_x - prev_x) + (val_x - max_x);
            end else begin
                delta_c = (max_x - prev_x) + (val_x - min_x);
            end
        end else begin
            delta_c = d0;
        end
    end

    // Saturating totals and the signed turn term.
    always_comb begin
        dsum_raw = (TOTAL_BITS + 1)'(r_dsum[r_ch]) + (TOTAL_BITS + 1)'(r_delta);
        if (dsum_raw[TOTAL_BITS] != dsum_raw[TOTAL_BITS-1]) begin
            dsum_c = dsum_raw[TOTAL_BITS] ? {1'b1, {(TOTAL_BITS-1){1'b0}}}
                                          : {1'b0, {(TOTAL_BITS-1){1'b1}}};
        end else begin
            dsum_c = dsum_raw[TOTAL_BITS-1:0];
        end

        tsum_raw = (TURN_BITS + 1)'(r_tsum[r_ch]) + (TURN_BITS + 1)'(r_term);
        if (tsum_raw[TURN_BITS] != tsum_raw[TURN_BITS-1]) begin
            tsum_c = tsum_raw[TURN_BITS] ? {1'b1, {(TURN_BITS-1){1'b0}}}
                                         : {1'b0, {(TURN_BITS-1){1'b1}}};
        end else begin
            tsum_c = tsum_raw[TURN_BITS-1:0];
        end

        delta_abs = r_delta[DELTA_BITS-1] ? DELTA_BITS'(-r_delta) : DELTA_BITS'(r_delta);
        range_abs = r_range[RANGE_BITS-1] ? RANGE_BITS'(-r_range) : RANGE_BITS'(r_range);
        term_pos  = {1'b0, div_rsp.quotient};
        term_c    = r_neg ? -$signed(term_pos) : $signed(term_pos);
    end

    always_comb begin
        div_req.start    = (r_state == S_ACC) && (r_range != '0);
        div_req.dividend = {delta_abs[MAG_BITS-1:0], {FRAC_BITS{1'b0}}};
        div_req.divisor  = range_abs[VALUE_BITS-1:0];
    end

    kwda_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_seen      <= '0;
        end else begin
            if (o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_ch    <= i_in.channel[CH_IDX_BITS-1:0];
                        r_value <= i_in.reading;
                        r_vmin  <= i_in.reading_min;
                        r_vmax  <= i_in.reading_max;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (!r_seen[r_ch]) begin
                        // First sample: store the reading and start the totals at zero.
                        r_seen[r_ch] <= 1'b1;
                        r_last[r_ch] <= r_value;
                        r_dsum[r_ch] <= '0;
                        r_tsum[r_ch] <= '0;
                        r_first      <= 1'b1;
                        r_delta      <= '0;
                        r_tot        <= '0;
                        r_turn       <= '0;
                        r_state      <= S_DONE;
                    end else begin
                        r_first <= 1'b0;
                        r_delta <= delta_c;
                        r_range <= range_c[RANGE_BITS-1:0];
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_last[r_ch] <= r_value;
                    r_dsum[r_ch] <= dsum_c;
                    r_tot        <= dsum_c;
                    r_neg        <= r_delta[DELTA_BITS-1] ^ r_range[RANGE_BITS-1];
                    if (r_range == '0) begin
                        r_turn  <= r_tsum[r_ch];
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_TERM;
                    end
                end
                S_TERM: begin
                    r_term  <= term_c;
                    r_state <= S_TURN;
                end
                S_TURN: begin
                    r_tsum[r_ch] <= tsum_c;
                    r_turn       <= tsum_c;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_o_first   <= r_first;
                        r_o_delta   <= r_delta;
                        r_o_total   <= r_tot;
                        r_o_turns   <= r_turn;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.first_sample = r_o_first;
    assign o_out.step_delta   = r_o_delta;
    assign o_out.total_delta  = r_o_total;
    assign o_out.total_turns  = r_o_turns;

endmodule
